@@ rtl/core/stw_pkg.sv @@
package stw_pkg;

	// stave construction kinds
	typedef enum logic [1:0] {
		KIND_INNER  = 2'd0,
		KIND_MIDDLE = 2'd1,
		KIND_OUTER  = 2'd2
	} stave_kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_KIND   = 2'd0,
		REG_RADIUS = 2'd1,
		REG_STEP   = 2'd2,
		REG_TILT   = 2'd3
	} cfg_reg_t;

	localparam int RADIUS_BITS  = 23;
	localparam int CFG_BITS     = 23;
	localparam int INDEX_BITS   = 14;

	// cordic: 30 rotations, angle in 2^-32 turn units, values in q4.30
	localparam int CORDIC_ITERS = 30;
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_GAIN  = 652032874;
	localparam int FRAC_BITS    = 30;

	localparam int ATAN_TURN32 [CORDIC_ITERS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	// construction offsets in half-micrometre units
	localparam int MID_MODULE_Z [4] = '{-632100, -210700, 210700, 632100};
	localparam int CHIP_PITCH_Z   = 60200;
	localparam int OUTER_MODULE_Z = 421400;
	localparam int CHIP_X         = 15100;
	localparam int HALF_X         = 25800;
	localparam int HALF_Y0        = 41340;
	localparam int HALF_Y1        = 44860;
	localparam int SENSOR_Y       = 32;
	localparam int INNER_Y        = 50;
	localparam int OUTER_Y        = 1380;

endpackage

@@ rtl/core/stw_front.sv @@
module stw_front
	import stw_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic [1:0]                    kind,
	input  logic [ANGLE_BITS-1:0]         phi_step,
	input  logic [ANGLE_BITS-1:0]         phi_tilt,
	input  logic [5:0]                    stave_index,
	input  logic                          half_index,
	input  logic [2:0]                    module_index,
	input  logic [3:0]                    chip_index,
	input  logic signed [COORD_BITS-1:0]  local_x,
	input  logic signed [COORD_BITS-1:0]  local_y,
	input  logic signed [COORD_BITS-1:0]  local_z,
	output logic                          err,
	output logic signed [COORD_BITS+3:0]  px,
	output logic signed [COORD_BITS+3:0]  py,
	output logic signed [COORD_BITS-1:0]  pz,
	output logic [ANGLE_BITS-1:0]         phi,
	output logic [ANGLE_BITS-1:0]         rot
);

	localparam int PW = COORD_BITS + 4;
	localparam logic signed [PW-1:0] ZMAX = {{(PW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [PW-1:0] ZMIN = ~ZMAX;
	localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

	logic signed [PW-1:0] x0, y0, z0, xf, zf, pz_w;
	logic [ANGLE_BITS+5:0] phi_prod;
	int zm;

	// classify indexes and add the construction offsets
	always_comb begin
		x0 = PW'(local_x);
		y0 = PW'(local_y) - PW'(SENSOR_Y);
		z0 = PW'(local_z);
		xf = chip_index[0] ? -x0 : x0;
		zf = chip_index[0] ? -z0 : z0;
		zm = (kind == KIND_MIDDLE) ? MID_MODULE_Z[module_index[1:0]]
			: (int'(module_index) - 3) * OUTER_MODULE_Z;
		err = 1'b1;
		px = x0;
		py = y0;
		pz_w = z0;
		unique case (kind)
			KIND_INNER: begin
				err = chip_index > 4'd8;
				py = y0 - PW'(INNER_Y);
				pz_w = z0 + PW'((int'(chip_index) - 4) * CHIP_PITCH_Z);
			end
			KIND_MIDDLE, KIND_OUTER: begin
				err = (chip_index > 4'd13) ||
					((kind == KIND_MIDDLE) ? (module_index > 3'd3) : (module_index > 3'd6));
				px = xf + PW'(chip_index[0] ? CHIP_X : -CHIP_X)
					+ PW'(half_index ? HALF_X : -HALF_X);
				py = y0 + PW'(half_index ? HALF_Y1 - OUTER_Y : HALF_Y0 - OUTER_Y);
				pz_w = zf + PW'((int'(chip_index[3:1]) - 3) * CHIP_PITCH_Z) + PW'(zm);
			end
			default: ;
		endcase
	end

	// z needs no rotation, saturate it here
	always_comb begin
		if (pz_w > ZMAX) begin
			pz = ZMAX[COORD_BITS-1:0];
		end else if (pz_w < ZMIN) begin
			pz = ZMIN[COORD_BITS-1:0];
		end else begin
			pz = pz_w[COORD_BITS-1:0];
		end
	end

	// stave angle and rotation angle, wrapping modulo one turn
	assign phi_prod = (ANGLE_BITS+6)'(stave_index) * (ANGLE_BITS+6)'(phi_step);
	assign phi = phi_prod[ANGLE_BITS-1:0];
	assign rot = phi + QUARTER + phi_tilt;

endmodule

@@ rtl/core/stw_queue.sv @@
module stw_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] rdata
);

	localparam int DEPTH = 4;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;

	assign full = (count_q == 3'(DEPTH));
	assign nonempty = (count_q != 3'd0);
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty |-> !pop) else $error("queue read while empty");
`endif

endmodule

@@ rtl/core/stw_back.sv @@
module stw_back
	import stw_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [RADIUS_BITS-1:0]      radius,
	input  logic                        q_valid,
	input  logic [2*ANGLE_BITS+3*COORD_BITS+8:0] q_data,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [COORD_BITS-1:0]       world_x,
	output logic [COORD_BITS-1:0]       world_y,
	output logic [COORD_BITS-1:0]       world_z,
	output logic                        index_error
);

	localparam int PW = COORD_BITS + 4;
	localparam int CW = CORDIC_W;
	localparam int N  = CORDIC_ITERS;
	localparam int MW = CW + PW + 2;
	localparam logic signed [MW-1:0] RND = MW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [MW-1:0] SMAX = {{(MW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [MW-1:0] SMIN = ~SMAX;

	// unpacked queue entry
	logic                          e_err;
	logic signed [PW-1:0]          e_px, e_py;
	logic [COORD_BITS-1:0]         e_pz;
	logic [ANGLE_BITS-1:0]         e_phi, e_rot;
	logic                          en;

	assign {e_rot, e_phi, e_pz, e_py, e_px, e_err} = q_data;
	assign en = !m_tvalid || m_tready;
	assign q_pop = en && q_valid;

	// cordic stages, rot angle (r*) and stave angle (t*)
	logic signed [CW-1:0] rx_s [N+1];
	logic signed [CW-1:0] ry_s [N+1];
	logic signed [CW-1:0] rz_s [N+1];
	logic signed [CW-1:0] tx_s [N+1];
	logic signed [CW-1:0] ty_s [N+1];
	logic signed [CW-1:0] tz_s [N+1];
	logic [1:0]           rq_s [N+1];
	logic [1:0]           tq_s [N+1];
	logic signed [PW-1:0] px_s [N+1];
	logic signed [PW-1:0] py_s [N+1];
	logic [COORD_BITS-1:0] pz_s [N+1];
	logic                 err_s [N+1];
	logic [N:0]           v_s;

	// load from the queue
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= CW'(CORDIC_GAIN);
			ry_s[0] <= '0;
			rz_s[0] <= CW'({e_rot[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
			tx_s[0] <= CW'(CORDIC_GAIN);
			ty_s[0] <= '0;
			tz_s[0] <= CW'({e_phi[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
			rq_s[0] <= e_rot[ANGLE_BITS-1:ANGLE_BITS-2];
			tq_s[0] <= e_phi[ANGLE_BITS-1:ANGLE_BITS-2];
			px_s[0] <= e_px;
			py_s[0] <= e_py;
			pz_s[0] <= e_pz;
			err_s[0] <= e_err;
		end
	end

	// one rotation per stage
	for (genvar gi = 0; gi < N; gi++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (!rz_s[gi][CW-1]) begin
					rx_s[gi+1] <= rx_s[gi] - (ry_s[gi] >>> gi);
					ry_s[gi+1] <= ry_s[gi] + (rx_s[gi] >>> gi);
					rz_s[gi+1] <= rz_s[gi] - CW'(ATAN_TURN32[gi]);
				end else begin
					rx_s[gi+1] <= rx_s[gi] + (ry_s[gi] >>> gi);
					ry_s[gi+1] <= ry_s[gi] - (rx_s[gi] >>> gi);
					rz_s[gi+1] <= rz_s[gi] + CW'(ATAN_TURN32[gi]);
				end
				if (!tz_s[gi][CW-1]) begin
					tx_s[gi+1] <= tx_s[gi] - (ty_s[gi] >>> gi);
					ty_s[gi+1] <= ty_s[gi] + (tx_s[gi] >>> gi);
					tz_s[gi+1] <= tz_s[gi] - CW'(ATAN_TURN32[gi]);
				end else begin
					tx_s[gi+1] <= tx_s[gi] + (ty_s[gi] >>> gi);
					ty_s[gi+1] <= ty_s[gi] - (tx_s[gi] >>> gi);
					tz_s[gi+1] <= tz_s[gi] + CW'(ATAN_TURN32[gi]);
				end
				rq_s[gi+1] <= rq_s[gi];
				tq_s[gi+1] <= tq_s[gi];
				px_s[gi+1] <= px_s[gi];
				py_s[gi+1] <= py_s[gi];
				pz_s[gi+1] <= pz_s[gi];
				err_s[gi+1] <= err_s[gi];
			end
		end
	end

	// quadrant restore
	logic signed [CW-1:0] c_s31, s_s31, cs_s31, ss_s31;
	logic signed [PW-1:0] px_s31, py_s31;
	logic [COORD_BITS-1:0] pz_s31;
	logic err_s31, v_s31;

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (rq_s[N])
				2'd0: begin c_s31 <= rx_s[N];  s_s31 <= ry_s[N];  end
				2'd1: begin c_s31 <= -ry_s[N]; s_s31 <= rx_s[N];  end
				2'd2: begin c_s31 <= -rx_s[N]; s_s31 <= -ry_s[N]; end
				default: begin c_s31 <= ry_s[N]; s_s31 <= -rx_s[N]; end
			endcase
			unique case (tq_s[N])
				2'd0: begin cs_s31 <= tx_s[N];  ss_s31 <= ty_s[N];  end
				2'd1: begin cs_s31 <= -ty_s[N]; ss_s31 <= tx_s[N];  end
				2'd2: begin cs_s31 <= -tx_s[N]; ss_s31 <= -ty_s[N]; end
				default: begin cs_s31 <= ty_s[N]; ss_s31 <= -tx_s[N]; end
			endcase
			px_s31 <= px_s[N];
			py_s31 <= py_s[N];
			pz_s31 <= pz_s[N];
			err_s31 <= err_s[N];
		end
	end

	// products
	logic signed [CW+PW-1:0] cpx_s32, spy_s32, spx_s32, cpy_s32;
	logic signed [CW+RADIUS_BITS:0] rc_s32, rs_s32;
	logic [COORD_BITS-1:0] pz_s32;
	logic err_s32, v_s32;
	logic signed [RADIUS_BITS:0] rad_sg;

	assign rad_sg = $signed({1'b0, radius});

	always_ff @(posedge clk) begin
		if (en) begin
			cpx_s32 <= c_s31 * px_s31;
			spy_s32 <= s_s31 * py_s31;
			spx_s32 <= s_s31 * px_s31;
			cpy_s32 <= c_s31 * py_s31;
			rc_s32 <= rad_sg * cs_s31;
			rs_s32 <= rad_sg * ss_s31;
			pz_s32 <= pz_s31;
			err_s32 <= err_s31;
		end
	end

	// sum, round and saturate
	logic signed [MW-1:0] sx, sy, qx, qy;
	logic [COORD_BITS-1:0] wx, wy;

	always_comb begin
		sx = MW'(cpx_s32) - MW'(spy_s32) + MW'(rc_s32) + RND;
		sy = MW'(spx_s32) + MW'(cpy_s32) + MW'(rs_s32) + RND;
		qx = sx >>> FRAC_BITS;
		qy = sy >>> FRAC_BITS;
		if (qx > SMAX) wx = SMAX[COORD_BITS-1:0];
		else if (qx < SMIN) wx = SMIN[COORD_BITS-1:0];
		else wx = qx[COORD_BITS-1:0];
		if (qy > SMAX) wy = SMAX[COORD_BITS-1:0];
		else if (qy < SMIN) wy = SMIN[COORD_BITS-1:0];
		else wy = qy[COORD_BITS-1:0];
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			world_x <= err_s32 ? '0 : wx;
			world_y <= err_s32 ? '0 : wy;
			world_z <= err_s32 ? '0 : pz_s32;
			index_error <= err_s32;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			v_s31 <= 1'b0;
			v_s32 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s <= {v_s[N-1:0], q_valid};
			v_s31 <= v_s[N];
			v_s32 <= v_s31;
			m_tvalid <= v_s32;
		end
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && index_error) |-> (world_x == '0 && world_y == '0 && world_z == '0))
		else $error("error result with non-zero coordinates");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_s[0]) else $error("popped entry not loaded");
`endif

endmodule

@@ rtl/core/sensor_to_world_transform_unit.sv @@
// Moves pixel hits from sensor-local to world coordinates. Input transactions carry the
// stave, half-stave, module and chip indexes and the local point; each yields one output
// transaction with the world point and an index error flag (coordinates zero on error).
// A new transaction is taken every clock cycle while s_tready is high. The two 30-stage
// cordic pipelines (stave angle and rotation angle) feed quadrant, multiply and sum
// stages. A 4-entry queue sits between the front classifier and the arithmetic pipeline.
// Configuration must be written only while idle; the block itself does not enforce it.
module sensor_to_world_transform_unit
	import stw_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// stave_index, half_index, module_index, chip_index, local_x, local_y, local_z
	input  logic [((INDEX_BITS+3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// world_x, world_y, world_z
	output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// index_error
	output logic m_tuser
);

	localparam int PW = COORD_BITS + 4;
	localparam int EW = 2*ANGLE_BITS + 3*COORD_BITS + 9;
	localparam int ODW = ((3*COORD_BITS+7)/8)*8;

	logic [1:0] kind_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [ANGLE_BITS-1:0] step_q, tilt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			radius_q <= '0;
			step_q <= '0;
			tilt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KIND:   kind_q <= cfg_data[1:0];
				REG_RADIUS: radius_q <= cfg_data[RADIUS_BITS-1:0];
				REG_STEP:   step_q <= ANGLE_BITS'(cfg_data[15:0]);
				REG_TILT:   tilt_q <= ANGLE_BITS'(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// front: classify and offset
	logic f_err;
	logic signed [PW-1:0] f_px, f_py;
	logic signed [COORD_BITS-1:0] f_pz;
	logic [ANGLE_BITS-1:0] f_phi, f_rot;

	stw_front #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.kind(kind_q),
		.phi_step(step_q),
		.phi_tilt(tilt_q),
		.stave_index(s_tdata[5:0]),
		.half_index(s_tdata[6]),
		.module_index(s_tdata[9:7]),
		.chip_index(s_tdata[13:10]),
		.local_x(s_tdata[INDEX_BITS +: COORD_BITS]),
		.local_y(s_tdata[INDEX_BITS+COORD_BITS +: COORD_BITS]),
		.local_z(s_tdata[INDEX_BITS+2*COORD_BITS +: COORD_BITS]),
		.err(f_err),
		.px(f_px),
		.py(f_py),
		.pz(f_pz),
		.phi(f_phi),
		.rot(f_rot)
	);

	// queue between front and back
	logic q_full, q_nonempty, q_pop;
	logic [EW-1:0] q_rdata;

	assign s_tready = !q_full;

	stw_queue #(.WIDTH(EW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(s_tvalid && !q_full),
		.wdata({f_rot, f_phi, f_pz, f_py, f_px, f_err}),
		.full(q_full),
		.pop(q_pop),
		.nonempty(q_nonempty),
		.rdata(q_rdata)
	);

	// back: rotation and translation
	logic [COORD_BITS-1:0] wx, wy, wz;

	stw_back #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.radius(radius_q),
		.q_valid(q_nonempty),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.world_x(wx),
		.world_y(wy),
		.world_z(wz),
		.index_error(m_tuser)
	);

	assign m_tdata = ODW'({wz, wy, wx});

endmodule
